/* src/assert_macros.svh */
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, quiet while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on the rising clock, quiet while reset is high.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

/* src/gpha_pkg.sv */
`timescale 1ns / 1ps

package gpha_pkg;

  // Fixed field widths of the request and response.
  localparam int FREE_INDEX_W = 16;
  localparam int GEN_W = 16;
  localparam int SLOT_INDEX_W = 7;

  // Default number of page slots.
  localparam int DEFAULT_SLOT_COUNT = 128;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FREED     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_REJECTED  = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOCATE = 1'b0,
    OP_FREE     = 1'b1
  } operation_t;

  typedef struct packed {
    operation_t              operation;
    logic [FREE_INDEX_W-1:0] free_index;
    logic [GEN_W-1:0]        free_generation;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [GEN_W-1:0]        slot_generation;
  } rsp_t;

endpackage

/* src/generational_page_handle_allocator_unit.sv */
`timescale 1ns / 1ps

// Page handle allocator: each request allocates a handle (slot index plus a
// 16-bit generation) or frees one, and produces exactly one response. Frees
// push the slot onto a LIFO stack that allocations pop first; when the stack
// is empty, never-used slots are taken in order and start at generation 1.
// Frees of a zero, out-of-range, stale or idle handle are rejected without
// changing state. The unit accepts one request per clock cycle while the
// response register is free or being emptied; the response passes through the
// registered read of the generation table and free stack, then the response register.
// No clearing pass is needed after reset.
module generational_page_handle_allocator_unit #(
  parameter int SLOT_COUNT = gpha_pkg::DEFAULT_SLOT_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  gpha_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output gpha_pkg::rsp_t rsp
);
  import gpha_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W = IDX_W + GEN_W;

  // Control state.
  logic                  s1_valid;
  logic [CNT_W-1:0]      free_count;
  logic [CNT_W-1:0]      high_water;
  logic [SLOT_COUNT-1:0] in_use;

  // Request held for the decision cycle.
  req_t                  s1_req;

  // Memories: generation per slot, and the free stack of {slot, generation}.
  logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];
  logic [ENT_W-1:0]      stk_mem [SLOT_COUNT];
  logic [GEN_W-1:0]      gen_rd;
  logic [ENT_W-1:0]      stk_rd;

  // Bypass of writes made in the same edge as the read.
  logic                  gen_fwd_hit;
  logic [GEN_W-1:0]      gen_fwd_data;
  logic                  stk_fwd_hit;
  logic [ENT_W-1:0]      stk_fwd_data;

  // Decision-cycle signals.
  logic                  req_fire;
  logic                  s1_fire;
  logic [IDX_W-1:0]      s1_idx;
  logic [IDX_W-1:0]      req_idx;
  logic                  out_of_range;
  logic [GEN_W-1:0]      gen_cur;
  logic [ENT_W-1:0]      stk_top;
  logic [GEN_W-1:0]      gen_bumped;
  logic                  do_pop;
  logic                  do_fresh;
  logic                  do_free;
  logic                  gen_we;
  logic [IDX_W-1:0]      gen_wa;
  logic [GEN_W-1:0]      gen_wd;
  logic                  push;
  logic [ENT_W-1:0]      push_data;
  logic [IDX_W-1:0]      use_idx;
  logic [CNT_W-1:0]      free_count_next;
  logic [CNT_W-1:0]      high_water_next;
  logic [CNT_W-1:0]      stk_ra_full;
  logic [IDX_W-1:0]      stk_ra;
  rsp_t                  rsp_next;

  // Handshake: the decision stage moves on whenever the response register
  // is free or being emptied.
  assign s1_fire   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_fire;
  assign req_fire  = req_valid && req_ready;

  assign s1_idx  = s1_req.free_index[IDX_W-1:0];
  assign req_idx = req.free_index[IDX_W-1:0];
  assign out_of_range = {1'b0, s1_req.free_index} >= (FREE_INDEX_W + 1)'(SLOT_COUNT);

  // Current table contents, with bypass of the previous request's writes.
  assign gen_cur = gen_fwd_hit ? gen_fwd_data : gen_rd;
  assign stk_top = stk_fwd_hit ? stk_fwd_data : stk_rd;

  // Next generation after a free, skipping zero on wrap.
  always_comb begin
    gen_bumped = gen_cur + GEN_W'(1);
    if (gen_bumped == '0) begin
      gen_bumped = GEN_W'(1);
    end
  end

  // Decide the request in the decision stage.
  always_comb begin
    do_pop   = 1'b0;
    do_fresh = 1'b0;
    do_free  = 1'b0;
    rsp_next = '{status: ST_REJECTED, slot_index: '0, slot_generation: '0};
    unique case (s1_req.operation)
      OP_ALLOCATE: begin
        if (free_count != '0) begin
          do_pop = 1'b1;
          rsp_next.status          = ST_ALLOCATED;
          rsp_next.slot_index      = SLOT_INDEX_W'(stk_top[ENT_W-1:GEN_W]);
          rsp_next.slot_generation = stk_top[GEN_W-1:0];
        end else if (high_water < CNT_W'(SLOT_COUNT)) begin
          do_fresh = 1'b1;
          rsp_next.status          = ST_ALLOCATED;
          rsp_next.slot_index      = SLOT_INDEX_W'(high_water[IDX_W-1:0]);
          rsp_next.slot_generation = GEN_W'(1);
        end else begin
          rsp_next.status = ST_EXHAUSTED;
        end
      end
      OP_FREE: begin
        if (!((s1_req.free_index == '0) && (s1_req.free_generation == '0)) &&
            !out_of_range && in_use[s1_idx] && (gen_cur == s1_req.free_generation)) begin
          do_free = 1'b1;
          rsp_next.status = ST_FREED;
        end
      end
      default: begin
        rsp_next.status = ST_REJECTED;
      end
    endcase
  end

  // State effects of the decided request, applied only on a transfer out of
  // the decision stage.
  always_comb begin
    gen_we          = s1_fire && (do_fresh || do_free);
    gen_wa          = do_fresh ? high_water[IDX_W-1:0] : s1_idx;
    gen_wd          = do_fresh ? GEN_W'(1) : gen_bumped;
    push            = s1_fire && do_free && (free_count < CNT_W'(SLOT_COUNT));
    push_data       = {s1_idx, gen_bumped};
    use_idx         = do_pop ? stk_top[ENT_W-1:GEN_W] : gen_wa;
    free_count_next = free_count;
    high_water_next = high_water;
    if (s1_fire && do_pop) begin
      free_count_next = free_count - CNT_W'(1);
    end else if (push) begin
      free_count_next = free_count + CNT_W'(1);
    end
    if (s1_fire && do_fresh) begin
      high_water_next = high_water + CNT_W'(1);
    end
  end

  // The next request reads the stack top as it stands after this edge.
  assign stk_ra_full = free_count_next - CNT_W'(1);
  assign stk_ra      = stk_ra_full[IDX_W-1:0];

  // Generation table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (req_fire) begin
      gen_rd <= gen_mem[req_idx];
    end
  end

  // Free stack: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[free_count[IDX_W-1:0]] <= push_data;
    end
    if (req_fire) begin
      stk_rd <= stk_mem[stk_ra];
    end
  end

  // Request register and bypass capture.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_req       <= req;
      gen_fwd_hit  <= gen_we && (gen_wa == req_idx);
      gen_fwd_data <= gen_wd;
      stk_fwd_hit  <= push;
      stk_fwd_data <= push_data;
    end
  end

  // Control state, slot-busy flags and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
      free_count <= '0;
      high_water <= '0;
      in_use     <= '0;
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      free_count <= free_count_next;
      high_water <= high_water_next;
      if (s1_fire && (do_pop || do_fresh)) begin
        in_use[use_idx] <= 1'b1;
      end else if (s1_fire && do_free) begin
        in_use[use_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp <= rsp_next;
    end
  end

  // Every slot on the stack was handed out from the high-water mark first.
  `ASSERT_CLK(a_stack_below_hw, free_count <= high_water, "free count above high-water mark")
  `ASSERT_CLK(a_hw_in_range, high_water <= CNT_W'(SLOT_COUNT), "high-water mark past slot count")
  `ASSERT_IMPL(a_alloc_gen_nonzero, rsp_valid && (rsp.status == ST_ALLOCATED),
               rsp.slot_generation != '0, "allocated handle has generation zero")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import gpha_pkg::*;

  localparam int SLOTS = DEFAULT_SLOT_COUNT;
  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  generational_page_handle_allocator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Free-running clock, 8 ns period.
  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow allocator state, updated on every request transfer.
  logic [SLOT_INDEX_W-1:0] free_lifo[$];
  int unsigned             fresh_mark;
  logic [GEN_W-1:0]        slot_gen [SLOTS];
  bit                      slot_busy [SLOTS];
  int                      live_slots[$];

  // Responses still owed by the block, oldest first.
  rsp_t pending_rsp[$];

  bit idle_on;
  int mismatches;
  int rsp_checked;
  int n_alloc;
  int n_freed;
  int n_exhausted;
  int n_rejected;

  // Applies one request to the shadow state and returns the response it owes.
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   s;
    int   idx;
    bit   got;
    res = '0;
    got = 1'b1;
    if (r.operation == OP_ALLOCATE) begin
      if (free_lifo.size() > 0) begin
        s = int'(free_lifo.pop_back());
      end else if (fresh_mark < SLOTS) begin
        s = int'(fresh_mark);
        fresh_mark++;
        slot_gen[s] = GEN_W'(1);
      end else begin
        got = 1'b0;
      end
      if (got) begin
        slot_busy[s] = 1'b1;
        live_slots.push_back(s);
        res.status = ST_ALLOCATED;
        res.slot_index = s[SLOT_INDEX_W-1:0];
        res.slot_generation = slot_gen[s];
        n_alloc++;
      end else begin
        res.status = ST_EXHAUSTED;
        n_exhausted++;
      end
    end else begin
      idx = int'(r.free_index);
      if ((idx == 0 && r.free_generation == 0) || idx >= SLOTS || !slot_busy[idx] ||
          slot_gen[idx] != r.free_generation) begin
        res.status = ST_REJECTED;
        n_rejected++;
      end else begin
        // The generation skips zero when it wraps.
        slot_gen[idx] = (slot_gen[idx] == GEN_MAX) ? GEN_W'(1) : slot_gen[idx] + GEN_W'(1);
        slot_busy[idx] = 1'b0;
        free_lifo.push_back(idx[SLOT_INDEX_W-1:0]);
        for (int k = 0; k < live_slots.size(); k++) begin
          if (live_slots[k] == idx) begin
            live_slots.delete(k);
            break;
          end
        end
        res.status = ST_FREED;
        n_freed++;
      end
    end
    return res;
  endfunction

  // Sends one request, with an optional idle burst first, and records the
  // response it owes once the transfer happens.
  task automatic send_request(input operation_t op, input logic [15:0] idx,
                              input logic [15:0] gen);
    req_t r;
    r.operation = op;
    r.free_index = idx;
    r.free_generation = gen;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    pending_rsp.push_back(apply_request(r));
  endtask

  task automatic send_alloc();
    send_request(OP_ALLOCATE, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_free(input int slot, input logic [15:0] gen);
    send_request(OP_FREE, 16'(slot), gen);
  endtask

  // Receiver side: random stall bursts while idling is on.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Response checker: every response transfer is matched against the oldest
  // owed response, field by field.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response status %0d index %0d generation %0d", $time,
                 rsp.status, rsp.slot_index, rsp.slot_generation);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        rsp_checked++;
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          mismatches++;
        end
        if (rsp.slot_index !== want.slot_index) begin
          $display("%0t: slot_index expected %0d actual %0d", $time, want.slot_index,
                   rsp.slot_index);
          mismatches++;
        end
        if (rsp.slot_generation !== want.slot_generation) begin
          $display("%0t: slot_generation expected %0d actual %0d", $time,
                   want.slot_generation, rsp.slot_generation);
          mismatches++;
        end
      end
    end
  end

  // Fresh slots, reuse order, and each kind of rejected free.
  task automatic test_basic_handles();
    idle_on = 1'b1;
    send_alloc();
    send_alloc();
    send_alloc();
    send_free(1, 16'd1);
    // Second free of the same handle hits an idle slot.
    send_free(1, 16'd1);
    // Stale generation on a live slot.
    send_free(2, 16'd5);
    send_free(2, 16'd0);
    // Zero handle.
    send_free(0, 16'd0);
    // Index out of range.
    send_free(SLOTS, 16'd1);
    send_request(OP_FREE, 16'hFFFF, 16'hFFFF);
    // The freed slot comes back with the next generation.
    send_alloc();
    send_free(0, 16'd1);
    send_free(2, 16'd1);
    // Last freed comes out first.
    send_alloc();
    send_alloc();
    // Old handle of a reused slot is stale now.
    send_free(0, 16'd1);
    send_alloc();
  endtask

  // Runs the pool dry, then asks for more.
  task automatic test_exhaustion();
    int pick;
    idle_on = 1'b1;
    while (live_slots.size() < SLOTS) send_alloc();
    send_alloc();
    send_alloc();
    pick = live_slots[$urandom_range(0, live_slots.size() - 1)];
    send_free(pick, slot_gen[pick]);
    send_alloc();
    send_alloc();
  endtask

  // Mostly legal traffic that drifts between filling and draining the pool,
  // mixed with stale, idle, out-of-range and zero handles.
  task automatic test_random_traffic(input int count);
    bit fill_phase;
    bit stretch_idle;
    int pick;
    int roll;
    logic [15:0] bad_gen;
    fill_phase = 1'b1;
    stretch_idle = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0) fill_phase = !fill_phase;
      if (i % 100 == 0) stretch_idle = ($urandom_range(0, 3) != 0);
      idle_on = (i < count - 300) ? stretch_idle : 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < (fill_phase ? 70 : 25)) begin
        send_alloc();
      end else if (roll < (fill_phase ? 90 : 85) && live_slots.size() > 0) begin
        pick = live_slots[$urandom_range(0, live_slots.size() - 1)];
        send_free(pick, slot_gen[pick]);
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            if (live_slots.size() > 0) begin
              pick = live_slots[$urandom_range(0, live_slots.size() - 1)];
              bad_gen = 16'($urandom_range(1, 65535));
              send_free(pick, slot_gen[pick] ^ bad_gen);
            end else begin
              send_alloc();
            end
          end
          1: begin
            // Any slot already touched, either generation guess.
            pick = $urandom_range(0, fresh_mark - 1);
            send_free(pick, $urandom_range(0, 1) ? slot_gen[pick] : 16'($urandom));
          end
          2: send_request(OP_FREE, 16'($urandom_range(SLOTS, 65535)), 16'($urandom));
          3: send_free(0, 16'd0);
          default: send_alloc();
        endcase
      end
    end
  endtask

  // Test sequence and end of run.
  initial begin
    int drain_wait;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_handles();
    test_exhaustion();
    test_random_traffic(1400);
    req_valid <= 1'b0;
    drain_wait = 0;
    while (pending_rsp.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (10) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
      mismatches++;
    end
    $display("Run sent %0d allocations, %0d frees, %0d exhausted and %0d rejected requests.",
             n_alloc, n_freed, n_exhausted, n_rejected);
    $display("Checked %0d responses in order against the shadow allocator.", rsp_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
